>>> hdl/bvfg_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage filter and gauge - shared package
// Types, widths and constants shared by the gauge unit and its divider.
// ----------------------------------------------------------------------------
package bvfg_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 32;
  localparam int MV_W      = 16;
  localparam int HP_W      = 8;
  localparam int WEIGHT_W  = 10;
  localparam int POINT_W   = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 24;

  // serial multiply / divide widths
  localparam int ACC_W     = 26;
  localparam int DSR_W     = 16;
  localparam int MUL_STEPS = 10;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 10'd1000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 10'd488;
  localparam logic [MV_W-1:0]     ROUND_HALF   = 16'd50;
  localparam logic [DSR_W-1:0]    TENTH_DIV    = 16'd100;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE = 4'd1;

  // breakpoint reset values: (2500,0) (2580,22) (2730,114) (2985,188) (3200,200)
  localparam logic [POINT_W-1:0] POINT_RESET [8] = '{
    24'd640000, 24'd660502, 24'd698994, 24'd764348,
    24'd819400, 24'd819400, 24'd819400, 24'd819400
  };

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FDIV,
    ST_TDIV,
    ST_SCAN,
    ST_IMUL,
    ST_IDIV,
    ST_DONE
  } state_t;

endpackage

>>> hdl/bvfg_sdiv.sv
// ----------------------------------------------------------------------------
// Battery voltage filter and gauge - serial divider
// Restoring divider, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
module bvfg_sdiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bvfg_pkg::div_req_t             req,
  output logic                           done,
  output logic [bvfg_pkg::ACC_W-1:0]     quot
);
  import bvfg_pkg::*;

  localparam int CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0] q_r, q_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, q_r[ACC_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt   = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in next dividend bit, subtract when it fits
      q_nxt   = {q_r[ACC_W-2:0], ge};
      rem_nxt = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ACC_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> hdl/battery_voltage_filter_and_gauge_unit.sv
// ----------------------------------------------------------------------------
// Battery voltage filter and gauge unit
// Smooths millivolt samples, rounds to 100 mV units, maps to charge level.
// ----------------------------------------------------------------------------
// Result time is set by one shared bit-serial divider (two divisions when the
//   charge clamps or hits a breakpoint, three when it interpolates), a 10-step
//   shift-add multiplier and, unless the charge clamps, a scan of the table.
// Throughput: one word at a time; the next is taken once the result is loaded.
// Reset (synchronous, rst_n low): weight 488, default table, no sample seen.
// ----------------------------------------------------------------------------
module battery_voltage_filter_and_gauge_unit #(
  parameter int NUM_POINTS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample_mv[15:0]
  input  logic [bvfg_pkg::IN_W-1:0]         in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // filtered_mv[15:0], volts_tenths[23:16], charge_half_percent[31:24]
  output logic [bvfg_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [bvfg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bvfg_pkg::CFG_W-1:0]        cfg_wdata
);
  import bvfg_pkg::*;

  localparam int SEL_W = $clog2(NUM_POINTS);

  // configuration
  logic [WEIGHT_W-1:0] weight_r;
  logic [POINT_W-1:0]  pt_r [NUM_POINTS];

  // filter state
  state_t              state_r, state_nxt;
  logic [MV_W-1:0]     smooth_r, smooth_nxt;
  logic                have_r, have_nxt;

  // shift-add multiplier: acc += a*wa + b*wb, one weight bit per cycle
  logic [ACC_W-1:0]    ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt, acc_sum;
  logic [WEIGHT_W-1:0] mwa_r, mwa_nxt, mwb_r, mwb_nxt;
  logic [3:0]          mcnt_r, mcnt_nxt;
  logic                mul_last;

  // gauge datapath
  logic [HP_W-1:0]     tenths_r, tenths_nxt;
  logic [HP_W-1:0]     charge_r, charge_nxt;
  logic [HP_W-1:0]     base_r, base_nxt;
  logic                neg_r, neg_nxt;
  logic [DSR_W-1:0]    span_r, span_nxt;
  logic [POINT_W-1:0]  prev_r, prev_nxt;
  logic [SEL_W-1:0]    scan_r, scan_nxt;

  // output stage
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [WEIGHT_W-1:0] w_clamp, w_use, w_rest;
  logic [POINT_W-1:0]  cur_pt;
  logic                lo_clamp, hi_clamp, found, hit, out_free;
  logic [MV_W-1:0]     dx, span_calc;
  logic [HP_W-1:0]     dy_mag;
  logic                dy_neg;

  div_req_t            div_req;
  logic                div_done;
  logic [ACC_W-1:0]    div_quot;

  bvfg_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // weight above full scale holds the value; no sample yet passes through
  assign w_clamp = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
  assign w_use   = have_r ? w_clamp : '0;
  assign w_rest  = WEIGHT_FULL - w_use;

  assign acc_sum  = acc_r + (mwa_r[0] ? ma_r : '0) + (mwb_r[0] ? mb_r : '0);
  assign mul_last = (mcnt_r == 4'(MUL_STEPS - 1));

  // end clamps read fixed breakpoints; the scan reads one entry a cycle
  assign lo_clamp = smooth_r <= pt_r[0][POINT_W-1:HP_W];
  assign hi_clamp = smooth_r >= pt_r[NUM_POINTS-1][POINT_W-1:HP_W];
  assign cur_pt   = pt_r[scan_r];
  assign found    = (smooth_r <= cur_pt[POINT_W-1:HP_W]) ||
                    (scan_r == SEL_W'(NUM_POINTS - 1));
  assign hit      = smooth_r == cur_pt[POINT_W-1:HP_W];

  // segment between prev (strictly below) and cur (strictly above)
  assign dx        = smooth_r - prev_r[POINT_W-1:HP_W];
  assign span_calc = cur_pt[POINT_W-1:HP_W] - prev_r[POINT_W-1:HP_W];
  assign dy_neg    = cur_pt[HP_W-1:0] < prev_r[HP_W-1:0];
  assign dy_mag    = dy_neg ? (prev_r[HP_W-1:0] - cur_pt[HP_W-1:0])
                            : (cur_pt[HP_W-1:0] - prev_r[HP_W-1:0]);

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_FMUL;
      ST_FMUL: if (mul_last) state_nxt = ST_FDIV;
      ST_FDIV: if (div_done) state_nxt = ST_TDIV;
      ST_TDIV: begin
        if (div_done) state_nxt = (lo_clamp || hi_clamp) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (found) state_nxt = hit ? ST_DONE : ST_IMUL;
      end
      ST_IMUL: if (mul_last) state_nxt = ST_IDIV;
      ST_IDIV: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    smooth_nxt    = smooth_r;
    have_nxt      = have_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    mwa_nxt       = mwa_r;
    mwb_nxt       = mwb_r;
    acc_nxt       = acc_r;
    mcnt_nxt      = mcnt_r;
    tenths_nxt    = tenths_r;
    charge_nxt    = charge_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    span_nxt      = span_r;
    prev_nxt      = prev_r;
    scan_nxt      = scan_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_req       = '{start: 1'b0, dividend: acc_sum, divisor: TENTH_DIV};
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // load old*w + (1000-w)*new
        ma_nxt    = ACC_W'(smooth_r);
        mb_nxt    = ACC_W'(in_tdata);
        mwa_nxt   = w_use;
        mwb_nxt   = w_rest;
        acc_nxt   = '0;
        mcnt_nxt  = '0;
      end
      ST_FMUL, ST_IMUL: begin
        acc_nxt  = acc_sum;
        ma_nxt   = {ma_r[ACC_W-2:0], 1'b0};
        mb_nxt   = {mb_r[ACC_W-2:0], 1'b0};
        mwa_nxt  = {1'b0, mwa_r[WEIGHT_W-1:1]};
        mwb_nxt  = {1'b0, mwb_r[WEIGHT_W-1:1]};
        mcnt_nxt = mcnt_r + 1'b1;
        if (mul_last) begin
          div_req.start    = 1'b1;
          div_req.dividend = acc_sum;
          div_req.divisor  = (state_r == ST_FMUL) ? DSR_W'(WEIGHT_FULL) : span_r;
        end
      end
      ST_FDIV: begin
        if (div_done) begin
          smooth_nxt       = div_quot[MV_W-1:0];
          have_nxt         = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = ACC_W'(div_quot[MV_W-1:0]) + ACC_W'(ROUND_HALF);
          div_req.divisor  = TENTH_DIV;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          // saturate the 100 mV count
          tenths_nxt = (div_quot[ACC_W-1:HP_W] != '0) ? '1 : div_quot[HP_W-1:0];
          if (lo_clamp) begin
            charge_nxt = pt_r[0][HP_W-1:0];
          end else if (hi_clamp) begin
            charge_nxt = pt_r[NUM_POINTS-1][HP_W-1:0];
          end
          prev_nxt = pt_r[0];
          scan_nxt = SEL_W'(1);
        end
      end
      ST_SCAN: begin
        if (found) begin
          if (hit) begin
            charge_nxt = cur_pt[HP_W-1:0];
          end else begin
            // load dx * |dy|, divide by span afterwards
            base_nxt = prev_r[HP_W-1:0];
            neg_nxt  = dy_neg;
            span_nxt = span_calc;
            ma_nxt   = ACC_W'(dx);
            mb_nxt   = '0;
            mwa_nxt  = WEIGHT_W'(dy_mag);
            mwb_nxt  = '0;
            acc_nxt  = '0;
            mcnt_nxt = '0;
          end
        end else begin
          prev_nxt = cur_pt;
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_IDIV: begin
        if (div_done) begin
          charge_nxt = neg_r ? (base_r - div_quot[HP_W-1:0])
                             : (base_r + div_quot[HP_W-1:0]);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_nxt  = {charge_r, tenths_r, smooth_r};
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      smooth_r    <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      scan_r      <= '0;
      weight_r    <= WEIGHT_RESET;
      for (int k = 0; k < NUM_POINTS; k++) begin
        pt_r[k] <= POINT_RESET[k % 8];
      end
    end else begin
      state_r     <= state_nxt;
      smooth_r    <= smooth_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      mcnt_r      <= mcnt_nxt;
      scan_r      <= scan_nxt;
      // drop writes beyond the table
      if (cfg_wr_en) begin
        if (cfg_index == REG_WEIGHT) begin
          weight_r <= cfg_wdata[WEIGHT_W-1:0];
        end
        for (int k = 0; k < NUM_POINTS; k++) begin
          if (cfg_index == REG_POINT_BASE + CFG_IDX_W'(k)) begin
            pt_r[k] <= cfg_wdata[POINT_W-1:0];
          end
        end
      end
    end
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    mwa_r      <= mwa_nxt;
    mwb_r      <= mwb_nxt;
    acc_r      <= acc_nxt;
    tenths_r   <= tenths_nxt;
    charge_r   <= charge_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    span_r     <= span_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

>>> tb/battery_voltage_filter_and_gauge_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery voltage filter and gauge unit - self-checking testbench
// Streams millivolt samples through the unit under changing weights and
// breakpoint tables, predicts every filtered/tenths/charge word in a
// scoreboard and compares each output word field by field.
// ----------------------------------------------------------------------------
module battery_voltage_filter_and_gauge_unit_test;
  import bvfg_pkg::*;

  localparam int NUM_PTS       = 5;
  localparam int TENTHS_MAX    = 255;
  localparam int IDX_MAX       = (1 << CFG_IDX_W) - 1;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_SAMPLES = 128;
  localparam int TAIL_CYCLES   = 150;   // longer than the interpolating latency
  localparam int REPORT_MAX    = 10;

  // Output word as it sits on out_tdata, lowest field last.
  typedef struct packed {
    logic [HP_W-1:0] charge_hp;
    logic [HP_W-1:0] tenths;
    logic [MV_W-1:0] mv;
  } gauge_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the weight, breakpoint table and filter state.
  // --------------------------------------------------------------------------
  class gauge_scoreboard;
    logic [WEIGHT_W-1:0] weight;
    logic [POINT_W-1:0]  bkpt [NUM_PTS];
    logic [MV_W-1:0]     level_mv;
    bit                  primed;
    gauge_word_t         expected_q [$];
    int unsigned         errors;
    int unsigned         words_seen;

    function new();
      weight = WEIGHT_RESET;
      foreach (bkpt[k]) bkpt[k] = POINT_RESET[k];
      level_mv   = '0;
      primed     = 1'b0;
      errors     = 0;
      words_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int knee_mv(int k);
      return int'(bkpt[k][POINT_W-1:HP_W]);
    endfunction

    function int knee_hp(int k);
      return int'(bkpt[k][HP_W-1:0]);
    endfunction

    // Clamp at both ends, return a breakpoint on an exact hit, else
    // interpolate between the bracketing pair (truncating toward zero).
    function logic [HP_W-1:0] charge_for(logic [MV_W-1:0] mv);
      int m, k, dx, dy, span;
      m = int'(mv);
      if (m <= knee_mv(0)) return HP_W'(knee_hp(0));
      if (m >= knee_mv(NUM_PTS - 1)) return HP_W'(knee_hp(NUM_PTS - 1));
      k = 1;
      while (k < NUM_PTS - 1 && m > knee_mv(k)) k++;
      if (k < NUM_PTS - 1 && m == knee_mv(k)) return HP_W'(knee_hp(k));
      dx   = m - knee_mv(k - 1);
      dy   = knee_hp(k) - knee_hp(k - 1);
      span = knee_mv(k) - knee_mv(k - 1);
      if (span <= 0) return HP_W'(knee_hp(k - 1));
      return HP_W'(dx * dy / span + knee_hp(k - 1));
    endfunction

    // Indexes past the table are dropped by the unit as well.
    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_WEIGHT)
        weight = data[WEIGHT_W-1:0];
      else if (idx >= REG_POINT_BASE && int'(idx) < int'(REG_POINT_BASE) + NUM_PTS)
        bkpt[int'(idx) - int'(REG_POINT_BASE)] = data[POINT_W-1:0];
    endfunction

    function void note_sample(logic [IN_W-1:0] sample);
      gauge_word_t want;
      int w, lvl, tenths;
      w = (int'(weight) > int'(WEIGHT_FULL)) ? int'(WEIGHT_FULL) : int'(weight);
      lvl = int'(sample);
      if (primed)
        lvl = (int'(level_mv) * w + (int'(WEIGHT_FULL) - w) * int'(sample))
              / int'(WEIGHT_FULL);
      level_mv = MV_W'(lvl);
      primed   = 1'b1;
      tenths = (int'(level_mv) + int'(ROUND_HALF)) / int'(TENTH_DIV);
      if (tenths > TENTHS_MAX) tenths = TENTHS_MAX;
      want.mv        = level_mv;
      want.tenths    = HP_W'(tenths);
      want.charge_hp = charge_for(level_mv);
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      gauge_word_t got, want;
      got = data;
      words_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("word %0d: unexpected, got mv=%0d tenths=%0d charge=%0d",
                   words_seen, got.mv, got.tenths, got.charge_hp);
        return;
      end
      want = expected_q.pop_front();
      if (got.mv !== want.mv || got.tenths !== want.tenths ||
          got.charge_hp !== want.charge_hp) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("word %0d: expected mv=%0d tenths=%0d charge=%0d, got mv=%0d tenths=%0d charge=%0d",
                   words_seen, want.mv, want.tenths, want.charge_hp,
                   got.mv, got.tenths, got.charge_hp);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and signals
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic [IN_W-1:0]      in_tdata;     // sample_mv[15:0]
  logic                 in_tvalid;
  logic                 in_tready;
  logic [OUT_W-1:0]     out_tdata;    // filtered_mv[15:0], volts_tenths[23:16],
                                      // charge_half_percent[31:24]
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  gauge_scoreboard sb;

  // Stall modes: when set, that side runs without gaps for the phase.
  bit in_steady;
  bit out_steady;

  // Breakpoint voltages of the table now loaded; used to aim the samples.
  logic [MV_W-1:0] knot_mv [NUM_PTS];

  always #10 clk = ~clk;

  battery_voltage_filter_and_gauge_unit #(
    .NUM_POINTS(NUM_PTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Sample every handshake on the edge it completes. Check the output word
  // before noting a new input: a word accepted now can never belong to it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
      if (cfg_wr_en) sb.note_write(cfg_index, cfg_wdata);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int pick_gap(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Hold valid high across back-to-back words; only drop it for a real gap,
  // and put noise on the data lines while it is low.
  task automatic send_sample(input logic [IN_W-1:0] mv);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= mv;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back, so the
  // unit is idle before any register write. The first edge lets the monitor
  // log the last accepted word.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Leave the write enable up across back-to-back writes; the caller drops
  // it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_point(input int k, input logic [POINT_W-1:0] pt);
    write_reg(CFG_IDX_W'(int'(REG_POINT_BASE) + k), CFG_W'(pt));
    knot_mv[k] = pt[POINT_W-1:HP_W];
  endtask

  // Mostly land around the table, some exact breakpoints, some anywhere.
  function automatic logic [IN_W-1:0] pick_sample();
    int lo, hi, roll;
    lo = 65535;
    hi = 0;
    foreach (knot_mv[k]) begin
      if (int'(knot_mv[k]) < lo) lo = int'(knot_mv[k]);
      if (int'(knot_mv[k]) > hi) hi = int'(knot_mv[k]);
    end
    roll = $urandom_range(0, 99);
    if (roll < 15) return knot_mv[$urandom_range(0, NUM_PTS - 1)];
    if (roll < 35) return IN_W'($urandom);
    lo = (lo > 64) ? lo - 64 : 0;
    hi = (hi < 65471) ? hi + 64 : 65535;
    return IN_W'($urandom_range(lo, hi));
  endfunction

  // Receiver: stall for a random gap before taking each word, none in steady mode.
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap(out_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int mode, base, w;
    logic [POINT_W-1:0] pt;

    sb = new();
    foreach (knot_mv[k]) knot_mv[k] = POINT_RESET[k][POINT_W-1:HP_W];
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first sample passes through, later ones smooth at 488.
    send_sample(16'd3000);
    send_sample(16'd2600);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    settle();

    // Weight zero: samples pass straight through. Hit the clamps, every
    // breakpoint exactly, the interpolated span and the tenths saturation.
    // Also poke the top and first unused indexes, which must be ignored.
    write_reg(REG_WEIGHT, CFG_W'(0));
    write_reg(CFG_IDX_W'(IDX_MAX), CFG_W'(24'hFFFFFF));
    write_reg(CFG_IDX_W'(NUM_PTS + 1), CFG_W'(24'h5A5A5A));
    cfg_wr_en <= 1'b0;
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd2500);
    send_sample(16'd2580);
    send_sample(16'd2730);
    send_sample(16'd2985);
    send_sample(16'd3200);
    send_sample(16'd2499);
    send_sample(16'd3201);
    send_sample(16'd2655);
    send_sample(16'd25449);
    send_sample(16'd25450);
    send_sample(16'd49);
    send_sample(16'd50);
    settle();

    // Weight above full scale and at full scale: the level holds still.
    write_reg(REG_WEIGHT, CFG_W'(1023));
    cfg_wr_en <= 1'b0;
    send_sample(16'd2000);
    send_sample(16'd3100);
    settle();
    write_reg(REG_WEIGHT, CFG_W'(WEIGHT_FULL));
    cfg_wr_en <= 1'b0;
    send_sample(16'd0);
    settle();

    // Table out of order, with a falling charge pair at the top end so the
    // interpolation runs downward and truncates toward zero.
    write_reg(REG_WEIGHT, CFG_W'(0));
    write_point(0, {16'd3000, 8'd200});
    write_point(1, {16'd2500, 8'd10});
    write_point(2, {16'd3500, 8'd60});
    write_point(3, {16'd3200, 8'd120});
    write_point(4, {16'd4000, 8'd0});
    cfg_wr_en <= 1'b0;
    send_sample(16'd3100);
    send_sample(16'd3601);
    send_sample(16'd2900);
    send_sample(16'd3999);
    settle();

    // Random phases: new weight and table each time, random stall modes.
    repeat (RAND_PHASES) begin
      case ($urandom_range(0, 5))
        0:       w = 0;
        1:       w = int'(WEIGHT_FULL);
        2:       w = $urandom_range(int'(WEIGHT_FULL) + 1, (1 << WEIGHT_W) - 1);
        default: w = $urandom_range(0, (1 << WEIGHT_W) - 1);
      endcase
      write_reg(REG_WEIGHT, CFG_W'(w));

      mode = $urandom_range(0, 7);
      base = $urandom_range(0, 62000);
      for (int k = 0; k < NUM_PTS; k++) begin
        case (mode)
          0: pt = POINT_RESET[k];
          1: pt = POINT_W'($urandom);
          default: begin
            // rising table, random charge direction per segment
            pt   = {MV_W'(base), HP_W'($urandom)};
            base = base + $urandom_range(1, 900);
            if (base > 65535) base = 65535;
          end
        endcase
        write_point(k, pt);
      end
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_IDX_W'($urandom_range(NUM_PTS + 1, IDX_MAX)), CFG_W'($urandom));
      cfg_wr_en <= 1'b0;

      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_SAMPLES) send_sample(pick_sample());
      settle();
    end

    // Catch any stray word after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("battery_voltage_filter_and_gauge_unit: match");
    else
      $display("battery_voltage_filter_and_gauge_unit: mismatch");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #30_000_000;
    $display("battery_voltage_filter_and_gauge_unit: mismatch");
    $finish;
  end

endmodule
